>>> src/bxds_pkg.sv
package bxds_pkg;

   localparam int NUM_CH       = 3;
   localparam int PIX_W        = 8;
   localparam int FACTOR_REG_W = 5;
   localparam int SIZE_REG_W   = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_IDX_W    = 2;

   localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = 5'd4;
   localparam logic [SIZE_REG_W-1:0]   SIZE_RESET   = 13'd4096;

   typedef logic [PIX_W-1:0] pixel_type;

   // register map of the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE  = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_reg_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic merge;
      logic div_start;
      logic load_out;
   } bxds_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic acc_hit;
      logic out_pending;
      logic div_busy;
      logic out_free;
   } bxds_status_type;

endpackage

>>> src/bxds_if.sv
interface bxds_req_if;
   logic                valid;
   logic                ready;
   bxds_pkg::pixel_type in_blue;
   bxds_pkg::pixel_type in_green;
   bxds_pkg::pixel_type in_red;

   modport source (output valid, output in_blue, output in_green, output in_red,
                   input ready);
   modport sink   (input valid, input in_blue, input in_green, input in_red,
                   output ready);
endinterface

interface bxds_rsp_if;
   logic                valid;
   logic                ready;
   bxds_pkg::pixel_type out_blue;
   bxds_pkg::pixel_type out_green;
   bxds_pkg::pixel_type out_red;
   logic                row_end;
   logic                frame_end;

   modport source (output valid, output out_blue, output out_green, output out_red,
                   output row_end, output frame_end, input ready);
   modport sink   (input valid, input out_blue, input out_green, input out_red,
                   input row_end, input frame_end, output ready);
endinterface

>>> src/bxds_ctrl.sv
module bxds_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bxds_pkg::bxds_status_type status,
   output bxds_pkg::bxds_cmd_type    cmd
);
   import bxds_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MERGE  = 3'b010,
      ST_DIVIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.acc_hit) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.out_pending) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (!status.div_busy && status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

>>> src/bxds_div.sv
module bxds_div #(
   parameter int MAX_SCALE = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [$clog2(MAX_SCALE*MAX_SCALE*255+1)-1:0] dividend [bxds_pkg::NUM_CH],
   input  logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0]     area,
   output bxds_pkg::pixel_type quotient [bxds_pkg::NUM_CH],
   output logic                busy
);
   import bxds_pkg::*;

   localparam int AREA_W = $clog2(MAX_SCALE*MAX_SCALE+1);
   localparam int CMP_W  = AREA_W + PIX_W;
   localparam int CNT_W  = $clog2(PIX_W);

   logic [CMP_W-1:0] rem_ff [NUM_CH];
   logic [CMP_W-1:0] rem_in [NUM_CH];
   pixel_type        quo_ff [NUM_CH];
   pixel_type        quo_in [NUM_CH];
   logic [CMP_W-1:0] dv_ff, dv_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   // restoring division, one quotient bit per cycle, three lanes in step
   always_comb begin
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         rem_in[c] = rem_ff[c];
         quo_in[c] = quo_ff[c];
      end
      if (start) begin
         dv_in   = CMP_W'(area) << (PIX_W - 1);
         cnt_in  = CNT_W'(PIX_W - 1);
         busy_in = 1'b1;
         for (int c = 0; c < NUM_CH; c++) begin
            rem_in[c] = CMP_W'(dividend[c]);
            quo_in[c] = '0;
         end
      end else if (busy_ff) begin
         dv_in = dv_ff >> 1;
         for (int c = 0; c < NUM_CH; c++) begin
            if (rem_ff[c] >= dv_ff) begin
               rem_in[c] = rem_ff[c] - dv_ff;
               quo_in[c] = {quo_ff[c][PIX_W-2:0], 1'b1};
            end else begin
               quo_in[c] = {quo_ff[c][PIX_W-2:0], 1'b0};
            end
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff <= dv_in;
      for (int c = 0; c < NUM_CH; c++) begin
         rem_ff[c] <= rem_in[c];
         quo_ff[c] <= quo_in[c];
      end
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;

endmodule

>>> src/bxds_datapath.sv
module bxds_datapath #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_SCALE = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             restart,
   input  logic [$clog2(MAX_SCALE+1)-1:0]   eff_f,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_h,
   input  bxds_pkg::pixel_type              pix_in [bxds_pkg::NUM_CH],
   input  bxds_pkg::bxds_cmd_type           cmd,
   output bxds_pkg::bxds_status_type        status,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output bxds_pkg::pixel_type              rsp_pix [bxds_pkg::NUM_CH],
   output logic                             rsp_row_end,
   output logic                             rsp_frame_end
);
   import bxds_pkg::*;

   localparam int POS_W  = $clog2(MAX_WIDTH);
   localparam int F_W    = $clog2(MAX_SCALE+1);
   localparam int XIN_W  = $clog2(MAX_SCALE);
   localparam int EXT_W  = ((POS_W > F_W) ? POS_W : F_W) + 2;
   localparam int PIX_MAX = (1 << PIX_W) - 1;
   localparam int HS_W   = $clog2(MAX_SCALE*PIX_MAX+1);
   localparam int SUM_W  = $clog2(MAX_SCALE*MAX_SCALE*PIX_MAX+1);
   localparam int AREA_W = $clog2(MAX_SCALE*MAX_SCALE+1);

   // raster position and block-grid counters
   logic [POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0] ox_ff, ox_in;
   logic [POS_W-1:0] bx_ff, bx_in, by_ff, by_in;
   logic [XIN_W-1:0] xin_ff, xin_in, yin_ff, yin_in;

   logic [HS_W-1:0]  hsum_ff [NUM_CH];
   logic [HS_W-1:0]  hsum_in [NUM_CH];

   // facts of the accepted item, held for the merge and output steps
   logic [POS_W-1:0] slot_ff, slot_in;
   logic             first_ff, first_in;
   logic             outp_ff, outp_in;
   logic             rend_ff, rend_in;
   logic             fend_ff, fend_in;

   logic [NUM_CH*SUM_W-1:0] mem [MAX_WIDTH];
   logic [NUM_CH*SUM_W-1:0] rd_ff;
   logic [NUM_CH*SUM_W-1:0] sum_word;
   logic [SUM_W-1:0]        sum [NUM_CH];

   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        rsp_pix_ff [NUM_CH];
   pixel_type        rsp_pix_in [NUM_CH];
   logic             rsp_row_ff, rsp_row_in;
   logic             rsp_frame_ff, rsp_frame_in;

   logic [XIN_W-1:0] f_last;
   logic [EXT_W-1:0] f_ext, w_ext, h_ext, bx_ext, by_ext;
   logic             col_last, row_last, xin_last, yin_last;
   logic             blk_valid, rend, fend;
   pixel_type        quo [NUM_CH];
   logic             div_busy;
   logic [AREA_W-1:0] area;

   assign f_last   = XIN_W'(eff_f - F_W'(1));
   assign f_ext    = EXT_W'(eff_f);
   assign w_ext    = EXT_W'(eff_w);
   assign h_ext    = EXT_W'(eff_h);
   assign bx_ext   = EXT_W'(bx_ff);
   assign by_ext   = EXT_W'(by_ff);
   assign col_last = (EXT_W'(col_ff) + EXT_W'(1)) >= w_ext;
   assign row_last = (EXT_W'(row_ff) + EXT_W'(1)) >= h_ext;
   assign xin_last = (xin_ff == f_last);
   assign yin_last = (yin_ff == f_last);
   // block lies wholly inside the image
   assign blk_valid = ((bx_ext + f_ext) <= w_ext) && ((by_ext + f_ext) <= h_ext);
   // no further whole block to the right / below
   assign rend = (bx_ext + (f_ext << 1)) > w_ext;
   assign fend = rend && ((by_ext + (f_ext << 1)) > h_ext);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ox_in  = ox_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      xin_in = xin_ff;
      yin_in = yin_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
         ox_in  = '0;
         bx_in  = '0;
         by_in  = '0;
         xin_in = '0;
         yin_in = '0;
      end else if (cmd.accept) begin
         if (col_last) begin
            col_in = '0;
            ox_in  = '0;
            bx_in  = '0;
            xin_in = '0;
            if (row_last) begin
               row_in = '0;
               by_in  = '0;
               yin_in = '0;
            end else begin
               row_in = row_ff + POS_W'(1);
               if (yin_last) begin
                  yin_in = '0;
                  by_in  = POS_W'(by_ext + f_ext);
               end else begin
                  yin_in = yin_ff + XIN_W'(1);
               end
            end
         end else begin
            col_in = col_ff + POS_W'(1);
            if (xin_last) begin
               xin_in = '0;
               bx_in  = POS_W'(bx_ext + f_ext);
               ox_in  = ox_ff + POS_W'(1);
            end else begin
               xin_in = xin_ff + XIN_W'(1);
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         hsum_in[c] = hsum_ff[c];
         if (cmd.accept && blk_valid) begin
            if (xin_ff == '0) begin
               hsum_in[c] = HS_W'(pix_in[c]);
            end else begin
               hsum_in[c] = hsum_ff[c] + HS_W'(pix_in[c]);
            end
         end
      end
      slot_in  = slot_ff;
      first_in = first_ff;
      outp_in  = outp_ff;
      rend_in  = rend_ff;
      fend_in  = fend_ff;
      if (cmd.accept) begin
         slot_in  = ox_ff;
         first_in = (yin_ff == '0);
         outp_in  = yin_last;
         rend_in  = rend;
         fend_in  = fend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         ox_ff  <= '0;
         bx_ff  <= '0;
         by_ff  <= '0;
         xin_ff <= '0;
         yin_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ox_ff  <= ox_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         xin_ff <= xin_in;
         yin_ff <= yin_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CH; c++) begin
         hsum_ff[c] <= hsum_in[c];
      end
      slot_ff  <= slot_in;
      first_ff <= first_in;
      outp_ff  <= outp_in;
      rend_ff  <= rend_in;
      fend_ff  <= fend_in;
   end

   // column sums: first source row of a block row overwrites the entry
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (first_ff) begin
            sum[c] = SUM_W'(hsum_ff[c]);
         end else begin
            sum[c] = rd_ff[c*SUM_W +: SUM_W] + SUM_W'(hsum_ff[c]);
         end
         sum_word[c*SUM_W +: SUM_W] = sum[c];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff <= mem[ox_ff];
      end
      if (cmd.merge) begin
         mem[slot_ff] <= sum_word;
      end
   end

   assign area = AREA_W'(eff_f) * AREA_W'(eff_f);

   bxds_div #(
      .MAX_SCALE (MAX_SCALE)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum),
      .area     (area),
      .quotient (quo),
      .busy     (div_busy)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_frame_in = rsp_frame_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         rsp_pix_in[c] = rsp_pix_ff[c];
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = rend_ff;
         rsp_frame_in = fend_ff;
         for (int c = 0; c < NUM_CH; c++) begin
            rsp_pix_in[c] = quo[c];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_frame_ff <= rsp_frame_in;
      for (int c = 0; c < NUM_CH; c++) begin
         rsp_pix_ff[c] <= rsp_pix_in[c];
      end
   end

   assign status.acc_hit     = blk_valid && xin_last;
   assign status.out_pending = outp_ff;
   assign status.div_busy    = div_busy;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pix       = rsp_pix_ff;
   assign rsp_row_end   = rsp_row_ff;
   assign rsp_frame_end = rsp_frame_ff;

endmodule

>>> src/box_average_downsampler_core.sv
// Channel  Dir  Handshake      Payload
// req_bus  in   valid / ready  in_blue, in_green, in_red (source pixel, raster order)
// rsp_bus  out  valid / ready  out_blue, out_green, out_red, row_end, frame_end
// csr_*    in   csr_we         csr_index, csr_wdata (no read-back)
//
// An item that closes a block segment adds a line-store read-modify-write step, and
// an item that completes a block also runs the restoring divider and then loads the
// output register, plus any wait for that register to drain. Reset is synchronous and
// active high; the line store is not cleared, as each entry is written by the first
// row of its block row.
// The output register lets new items in while a result waits; a second result waits in place.
module box_average_downsampler_core #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_SCALE = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   bxds_req_if.sink                          req_bus,
   bxds_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [bxds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bxds_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bxds_pkg::*;

   localparam int SIZE_W = $clog2(MAX_WIDTH+1);
   localparam int F_W    = $clog2(MAX_SCALE+1);

   logic [FACTOR_REG_W-1:0] scale_ff, scale_in;
   logic [SIZE_REG_W-1:0]   width_ff, width_in;
   logic [SIZE_REG_W-1:0]   height_ff, height_in;
   logic                    restart;

   logic [F_W-1:0]          eff_f;
   logic [SIZE_W-1:0]       eff_w, eff_h;

   bxds_cmd_type            cmd;
   bxds_status_type         status;
   pixel_type               req_pix [NUM_CH];
   pixel_type               rsp_pix [NUM_CH];

   // csr writes; any known register restarts the frame
   always_comb begin
      scale_in  = scale_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_SCALE: begin
               scale_in = csr_wdata[FACTOR_REG_W-1:0];
               restart  = 1'b1;
            end
            CSR_WIDTH: begin
               width_in = csr_wdata[SIZE_REG_W-1:0];
               restart  = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = csr_wdata[SIZE_REG_W-1:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= FACTOR_RESET;
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else begin
         scale_ff  <= scale_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero means one; larger than the build limit saturates
   always_comb begin
      if (scale_ff == '0) begin
         eff_f = F_W'(1);
      end else if (int'(scale_ff) > MAX_SCALE) begin
         eff_f = F_W'(MAX_SCALE);
      end else begin
         eff_f = F_W'(scale_ff);
      end
      if (width_ff == '0) begin
         eff_w = SIZE_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         eff_w = SIZE_W'(MAX_WIDTH);
      end else begin
         eff_w = SIZE_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = SIZE_W'(1);
      end else if (int'(height_ff) > MAX_WIDTH) begin
         eff_h = SIZE_W'(MAX_WIDTH);
      end else begin
         eff_h = SIZE_W'(height_ff);
      end
   end

   // channel order in the datapath: blue, green, red
   assign req_pix[0] = req_bus.in_blue;
   assign req_pix[1] = req_bus.in_green;
   assign req_pix[2] = req_bus.in_red;

   bxds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bxds_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .eff_f         (eff_f),
      .eff_w         (eff_w),
      .eff_h         (eff_h),
      .pix_in        (req_pix),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_pix       (rsp_pix),
      .rsp_row_end   (rsp_bus.row_end),
      .rsp_frame_end (rsp_bus.frame_end)
   );

   assign rsp_bus.out_blue  = rsp_pix[0];
   assign rsp_bus.out_green = rsp_pix[1];
   assign rsp_bus.out_red   = rsp_pix[2];

endmodule

>>> src/bxds_checker.sv
module bxds_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bxds_pkg::pixel_type rsp_blue,
   input bxds_pkg::pixel_type rsp_green,
   input bxds_pkg::pixel_type rsp_red,
   input logic                rsp_row_end,
   input logic                rsp_frame_end
);

   // result valid holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // stalled result payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_blue) && $stable(rsp_green)
                                  && $stable(rsp_red) && $stable(rsp_row_end)
                                  && $stable(rsp_frame_end))
      else $error("rsp payload changed while stalled");

   // last pixel of a frame is also last of its row
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_frame_end || rsp_row_end)
      else $error("frame_end without row_end");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a result needs at least the merge and divide steps after an item
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after an item");

endmodule

bind box_average_downsampler_core bxds_checker u_bxds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_blue      (rsp_bus.out_blue),
   .rsp_green     (rsp_bus.out_green),
   .rsp_red       (rsp_bus.out_red),
   .rsp_row_end   (rsp_bus.row_end),
   .rsp_frame_end (rsp_bus.frame_end)
);

>>> tb/tb_box_average_downsampler_core.sv
`timescale 1ns / 100ps

module tb_box_average_downsampler_core;
   import bxds_pkg::*;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_SCALE     = 16;
   localparam int IDLE_PCT      = 19;    // chance in a hundred that a side idles
   localparam int SETTLE_CYCLES = 24;    // segment RMW + divider + output reg, with margin
   localparam int STALL_LIMIT   = 4000;  // cycles with no item moved on either side
   localparam int RANDOM_ITEMS  = 1100;

   // index 3 is not in the register map; writing it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      pixel_type blue;
      pixel_type green;
      pixel_type red;
   } source_pixel_type;

   typedef struct packed {
      pixel_type blue;
      pixel_type green;
      pixel_type red;
      logic      row_end;
      logic      frame_end;
   } block_average_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bxds_req_if req_bus ();
   bxds_rsp_if rsp_bus ();

   box_average_downsampler_core #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_SCALE (MAX_SCALE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Shadow of the block: registers, raster position, running sums, line store
   // ---------------------------------------------------------------------------------
   logic [FACTOR_REG_W-1:0] scale_reg  = FACTOR_RESET;
   logic [SIZE_REG_W-1:0]   width_reg  = SIZE_RESET;
   logic [SIZE_REG_W-1:0]   height_reg = SIZE_RESET;
   logic [11:0] col_pos = '0;
   logic [11:0] row_pos = '0;
   logic [15:0] run_sum [NUM_CH] = '{default: '0};
   logic [15:0] column_sums [MAX_WIDTH][NUM_CH];

   source_pixel_type  pending_pixels [$];     // waiting for the driver
   block_average_type expected_averages [$];  // predicted, not yet seen on rsp

   bit calm = 1'b0;      // set for whole phases: neither side idles
   bit req_taken;        // an item went in at the last rising edge
   int stuck_cycles;
   int fault_count = 0;

   // size registers: zero acts as 1, anything past the line store saturates
   function automatic int clamp_size(logic [SIZE_REG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_WIDTH) return MAX_WIDTH;
      return int'(raw);
   endfunction

   // A write to a mapped register restarts the frame; the spare index is dropped.
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SCALE:  scale_reg  = data[FACTOR_REG_W-1:0];
         CSR_WIDTH:  width_reg  = data;
         CSR_HEIGHT: height_reg = data;
         default: return;
      endcase
      col_pos = '0;
      row_pos = '0;
      run_sum = '{default: '0};
   endfunction

   // Fold one source pixel into the box sums; queue an average when a block closes.
   function automatic void fold_pixel(source_pixel_type px);
      int f, w, h, ow, oh, col, row, ox, oy, xin, yin, c;
      logic [15:0] chan [NUM_CH];
      block_average_type avg;
      f = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : int'(scale_reg));
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      ow = w / f;
      oh = h / f;
      col = col_pos;
      row = row_pos;
      ox = col / f;
      xin = col % f;
      oy = row / f;
      yin = row % f;
      chan[0] = 16'(px.blue);
      chan[1] = 16'(px.green);
      chan[2] = 16'(px.red);
      // pixels right of the last whole block or below the last block row are dropped
      if (ox < ow && oy < oh) begin
         for (c = 0; c < NUM_CH; c++)
            run_sum[c] = (xin == 0) ? chan[c] : run_sum[c] + chan[c];
         if (xin == f - 1) begin
            // first row of a block row overwrites the line store entry
            for (c = 0; c < NUM_CH; c++)
               column_sums[ox][c] = (yin == 0) ? run_sum[c] : column_sums[ox][c] + run_sum[c];
            if (yin == f - 1) begin
               avg.blue      = 8'(column_sums[ox][0] / (f * f));
               avg.green     = 8'(column_sums[ox][1] / (f * f));
               avg.red       = 8'(column_sums[ox][2] / (f * f));
               avg.row_end   = (ox == ow - 1);
               avg.frame_end = avg.row_end && (oy == oh - 1);
               expected_averages.push_back(avg);
            end
         end
      end
      // raster advance, wrapping to a new frame after the last pixel
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_pos = col[11:0];
      row_pos = row[11:0];
   endfunction

   task automatic check_field(string label, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t mismatch in %s: expected %0d, actual %0d", $time, label, want, got);
         fault_count++;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Driver: everything changes on the falling edge
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin : drive_pixels
      source_pixel_type next_pixel;
      // hold an item until taken; only then decide on the next one or a gap
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (pending_pixels.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_pixel = pending_pixels.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.in_blue  <= next_pixel.blue;
            req_bus.in_green <= next_pixel.green;
            req_bus.in_red   <= next_pixel.red;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // ---------------------------------------------------------------------------------
   // Monitor: samples on the rising edge, checks results, predicts from inputs
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      block_average_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         stuck_cycles <= 0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         // results first, so an item taken at this edge cannot match itself
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_averages.size() == 0) begin
               $display("%0t unexpected item: expected none, actual b=%0d g=%0d r=%0d",
                        $time, rsp_bus.out_blue, rsp_bus.out_green, rsp_bus.out_red);
               fault_count++;
            end else begin
               want = expected_averages.pop_front();
               check_field("out_blue",  want.blue,      rsp_bus.out_blue);
               check_field("out_green", want.green,     rsp_bus.out_green);
               check_field("out_red",   want.red,       rsp_bus.out_red);
               check_field("row_end",   want.row_end,   rsp_bus.row_end);
               check_field("frame_end", want.frame_end, rsp_bus.frame_end);
            end
         end
         if (req_bus.valid && req_bus.ready)
            fold_pixel('{req_bus.in_blue, req_bus.in_green, req_bus.in_red});
         // watchdog
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   // one-cycle write pulse; the shadow takes it at the same edge as the block
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly random colour, with some saturated white and black for the sum extremes
   task automatic feed_random(int count);
      int style;
      source_pixel_type px;
      repeat (count) begin
         style = $urandom_range(0, 9);
         if (style == 0)
            px = '{8'hFF, 8'hFF, 8'hFF};
         else if (style == 1)
            px = '0;
         else
            px = source_pixel_type'(24'($urandom));
         pending_pixels.push_back(px);
      end
   endtask

   // idle point: all items in, all averages out, then room for a segment that
   // closes without a result to finish inside the block
   task automatic wait_drain();
      while (pending_pixels.size() != 0 || req_bus.valid || expected_averages.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      int f_raw, w_raw, h_raw, n, first, pick, phase_no, random_items;
      req_bus.valid    = 1'b0;
      req_bus.in_blue  = '0;
      req_bus.in_green = '0;
      req_bus.in_red   = '0;
      rsp_bus.ready    = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      // Reset settings (4x, 4096x4096): a few pixels, far from closing any block.
      pending_pixels.push_back('{8'hFF, 8'h00, 8'hFF});
      pending_pixels.push_back('{8'h00, 8'hFF, 8'h00});
      pending_pixels.push_back('{8'h80, 8'h7F, 8'h01});
      pending_pixels.push_back('{8'hFE, 8'h01, 8'h80});
      wait_drain();

      // factor 1 on a 2x2 frame: every pixel comes straight out, row and frame ends
      write_reg(CSR_SCALE, 13'd1);
      write_reg(CSR_WIDTH, 13'd2);
      write_reg(CSR_HEIGHT, 13'd2);
      pending_pixels.push_back('{8'h00, 8'h00, 8'h00});
      pending_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
      pending_pixels.push_back('{8'hAA, 8'h55, 8'h0F});
      pending_pixels.push_back('{8'h55, 8'hAA, 8'hF0});
      wait_drain();

      // zero factor and zero sizes act as 1: a one-pixel frame that wraps each item
      write_reg(CSR_SCALE, 13'd0);
      write_reg(CSR_WIDTH, 13'd0);
      write_reg(CSR_HEIGHT, 13'd0);
      pending_pixels.push_back('{8'hFF, 8'h00, 8'h80});
      pending_pixels.push_back('{8'h01, 8'h02, 8'h03});
      wait_drain();

      // 2x on 5x2 with junk above the factor field: right-hand column dropped;
      // the spare index is written between the rows and must not restart the frame
      write_reg(CSR_SCALE, {8'hA5, 5'd2});
      write_reg(CSR_WIDTH, 13'd5);
      write_reg(CSR_HEIGHT, 13'd2);
      repeat (5) pending_pixels.push_back('{8'hFF, 8'hFF, 8'hFF});
      wait_drain();
      write_reg(CSR_SPARE, 13'h1FFF);
      repeat (5) pending_pixels.push_back('{8'hFF, 8'hFE, 8'h00});
      wait_drain();

      // factor 31 saturates to 16, larger than a 3x3 frame: nothing comes out
      write_reg(CSR_SCALE, 13'd31);
      write_reg(CSR_WIDTH, 13'd3);
      write_reg(CSR_HEIGHT, 13'd3);
      repeat (3) pending_pixels.push_back('{8'h12, 8'h34, 8'h56});
      wait_drain();

      // Random part: one setting per phase, whole frames plus a ragged tail.
      phase_no     = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         calm = (phase_no % 4 == 1);
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            // small factor, a few blocks each way, with partial edges
            f_raw = $urandom_range(1, 4);
            w_raw = f_raw * $urandom_range(1, 6) + $urandom_range(0, f_raw - 1);
            h_raw = f_raw * $urandom_range(1, 4) + $urandom_range(0, f_raw - 1);
            n     = w_raw * h_raw * $urandom_range(1, 2) + $urandom_range(0, w_raw);
         end else if (pick == 6) begin
            // factor register out of range: zero acts as 1, above 16 as 16
            f_raw = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_SCALE + 1, 31);
            if (f_raw == 0) begin
               w_raw = $urandom_range(0, 5);
               h_raw = $urandom_range(0, 5);
            end else begin
               w_raw = MAX_SCALE + $urandom_range(0, 2);
               h_raw = MAX_SCALE;
            end
            n = clamp_size(w_raw) * clamp_size(h_raw) + $urandom_range(0, w_raw);
         end else if (pick == 7) begin
            // full-width lines, possibly saturated; only part of the first row is sent
            f_raw = $urandom_range(0, 1);
            w_raw = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(MAX_WIDTH + 1, 8191);
            h_raw = $urandom_range(0, 3);
            n     = $urandom_range(40, 120);
         end else if (pick == 8) begin
            // very tall frame, narrow lines
            f_raw = $urandom_range(1, 3);
            w_raw = f_raw * $urandom_range(1, 3);
            h_raw = $urandom_range(MAX_WIDTH, 8191);
            n     = $urandom_range(60, 150);
         end else begin
            // factor larger than one of the sizes: no output at all
            f_raw = $urandom_range(2, MAX_SCALE);
            w_raw = $urandom_range(1, f_raw - 1);
            h_raw = $urandom_range(1, 5);
            if ($urandom_range(0, 1)) begin
               first = w_raw;
               w_raw = h_raw;
               h_raw = first;
            end
            n = 2 * w_raw * h_raw;
         end
         // keep the total close to the target
         if (n > RANDOM_ITEMS - random_items)
            n = RANDOM_ITEMS - random_items;

         write_reg(CSR_SCALE, {8'($urandom), 5'(f_raw)});
         write_reg(CSR_WIDTH, 13'(w_raw));
         write_reg(CSR_HEIGHT, 13'(h_raw));

         // sometimes break the phase: a pause, a spare-index write that keeps the
         // position, or a rewrite of a register that restarts the frame mid-way
         if (n >= 2 && $urandom_range(0, 1)) begin
            first = $urandom_range(1, n - 1);
            feed_random(first);
            wait_drain();
            case ($urandom_range(0, 3))
               0: write_reg(CSR_SPARE, 13'($urandom));
               1: write_reg(CSR_HEIGHT, height_reg);
               2: write_reg(CSR_WIDTH, width_reg);
               default: ;
            endcase
            feed_random(n - first);
         end else begin
            feed_random(n);
         end
         wait_drain();
         random_items += n;
         phase_no++;
      end

      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
